>>> rtl/core/rtse_pkg.sv
// Package with the types and constants of the rate to spike encoder.
package rtse_pkg;

  localparam int unsigned NEURONS_DEF    = 4096;
  localparam int unsigned MAX_SPIKES_DEF = 16;

  localparam logic [39:0] TIME_ALL_ONES = 40'hFF_FFFF_FFFF;
  localparam logic [32:0] UNWARPED_ONE  = 33'h0_0100_0000;
  localparam int unsigned DIV_STEPS     = 36;

  typedef enum logic [2:0] {
    REG_THRESHOLD   = 3'd0,
    REG_GAIN        = 3'd1,
    REG_BASE_RATE   = 3'd2,
    REG_REFRACTORY  = 3'd3,
    REG_FIRST_DELAY = 3'd4,
    REG_SLOT_LENGTH = 3'd5,
    REG_WIN_START   = 3'd6,
    REG_WIN_END     = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_RATE,
    ST_DIV,
    ST_CAND,
    ST_DEC_MUL,
    ST_DEC_SUB,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic [11:0]        neuron_index;
    logic signed [15:0] intensity;
    logic [39:0]        slot_start;
  } item_t;

  typedef struct packed {
    logic [11:0] spike_neuron;
    logic [39:0] spike_time;
    logic        last_of_run;
    logic        truncated;
  } result_t;

  typedef struct packed {
    logic        started;
    logic        fired;
    logic [39:0] last_spike;
    logic [31:0] unwarped;
  } neuron_word_t;

endpackage

>>> rtl/core/rate_to_spike_encoder_unit.sv
// Top level of the rate to spike encoder: control, neuron memory and spike buffer.
//
// One word on item starts a neuron's slot; it is taken at an edge with start high and
// busy low. The word sets a firing rate from the pixel and the configuration, reads
// the neuron's state from the neuron memory, and finds each spike time with a
// restoring divider that takes one quotient bit per cycle, followed by a candidate
// check. Spikes are kept in a small buffer, the neuron word is written back, and
// then each spike leaves on result, after a read state, with done high for one
// cycle. Busy stays high until the last spike has left, and the next word can be
// taken once busy is low. A rejected item goes back to idle from the check, an
// item with zero rate from the rate step; neither writes the neuron memory.
// The receiver cannot stall: every result word must be taken in its cycle.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must write it only while busy is low, which the block itself does not enforce.
// After reset the block sweeps the neuron memory, one entry a cycle, with busy high;
// configuration writes are taken during it.
module rate_to_spike_encoder_unit
  import rtse_pkg::*;
#(
  parameter int unsigned NEURONS    = NEURONS_DEF,
  parameter int unsigned MAX_SPIKES = MAX_SPIKES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned CW = $clog2(MAX_SPIKES + 1);
  localparam int unsigned BW = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;

  logic signed [15:0] thresh_level;
  logic [23:0] rate_gain;
  logic [23:0] base_rate;
  logic [31:0] refractory_period;
  logic [31:0] first_spike_delay;
  logic [31:0] slot_length;
  logic [39:0] window_start;
  logic [39:0] window_end;

  state_t state, state_next;

  neuron_word_t mem [NEURONS];
  neuron_word_t mem_q;
  logic         mem_we;
  logic [AW-1:0] mem_wa;
  neuron_word_t mem_wd;

  logic [39:0] spike_buf [MAX_SPIKES];
  logic [39:0] buf_q;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr;
  logic [11:0]   idx;
  logic signed [15:0] pix;
  logic [39:0]   slot_start;
  logic [39:0]   prod;
  logic [32:0]   rate;
  logic [31:0]   u;
  logic          fired;
  logic [42:0]   last;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic          trunc;
  logic [32:0]   rem;
  logic [35:0]   dvd;
  logic [5:0]    step;
  logic [48:0]   p_hi;
  logic [47:0]   p_lo;

  logic signed [16:0] diff;
  logic [40:0]   win_end_sum;
  logic          reject;
  logic [32:0]   rate_sum;
  logic [33:0]   div_sh;
  logic          div_ge;
  logic [42:0]   t_raw;
  logic [42:0]   bound;
  logic [42:0]   t_c;
  logic [42:0]   rel;
  logic [32:0]   u_inc;
  logic [61:0]   dec;
  logic [31:0]   u_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_level      <= '0;
      rate_gain         <= 24'd256;
      base_rate         <= '0;
      refractory_period <= '0;
      first_spike_delay <= 32'd16777216;
      slot_length       <= 32'd1048;
      window_start      <= '0;
      window_end        <= TIME_ALL_ONES;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:   thresh_level      <= cfg_data[15:0];
        REG_GAIN:        rate_gain         <= cfg_data[23:0];
        REG_BASE_RATE:   base_rate         <= cfg_data[23:0];
        REG_REFRACTORY:  refractory_period <= cfg_data[31:0];
        REG_FIRST_DELAY: first_spike_delay <= cfg_data[31:0];
        REG_SLOT_LENGTH: slot_length       <= cfg_data[31:0];
        REG_WIN_START:   window_start      <= cfg_data;
        REG_WIN_END:     window_end        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_CAND && rel < {11'd0, slot_length} && count != CW'(MAX_SPIKES)) begin
      spike_buf[count[BW-1:0]] <= t_c[39:0];
    end
    buf_q <= spike_buf[rd_idx[BW-1:0]];
  end

  always_comb begin
    diff        = 17'(pix) - 17'(thresh_level);
    win_end_sum = {1'b0, slot_start} + 41'(slot_length);
    reject      = ({20'd0, idx} >= 32'(NEURONS)) || (slot_start < window_start) ||
                  (win_end_sum > {1'b0, window_end}) || (pix < thresh_level);
    rate_sum    = {1'b0, prod[39:8]} + 33'(base_rate);
    div_sh      = {rem, dvd[35]};
    div_ge      = div_sh >= {1'b0, rate};
    t_raw       = {3'd0, slot_start} + 43'(dvd);
    bound       = last + 43'(refractory_period);
    t_c         = (fired && t_raw < bound) ? bound : t_raw;
    rel         = t_c - {3'd0, slot_start};
    u_inc       = {1'b0, u} + UNWARPED_ONE;
    dec         = {1'b0, p_hi, 12'd0} + 62'(p_lo[47:4]);
    u_dec       = (dec >= 62'(u)) ? 32'd0 : (u - dec[31:0]);
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = clr_addr;
    mem_wd     = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == AW'(NEURONS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = reject ? ST_IDLE : ST_RATE;
      end
      ST_RATE: begin
        state_next = (rate_sum == '0) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (step == 6'(DIV_STEPS - 1)) begin
          state_next = ST_CAND;
        end
      end
      ST_CAND: begin
        if (rel >= {11'd0, slot_length} || count == CW'(MAX_SPIKES)) begin
          state_next = ST_DEC_MUL;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DEC_MUL: begin
        state_next = ST_DEC_SUB;
      end
      ST_DEC_SUB: begin
        mem_we     = 1'b1;
        mem_wa     = addr;
        mem_wd     = '{started: 1'b1, fired: fired, last_spike: last[39:0],
                       unwarped: u_dec};
        state_next = (count == '0) ? ST_IDLE : ST_READ;
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        state_next = (rd_idx == count - CW'(1)) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx        <= item.neuron_index;
        addr       <= AW'(item.neuron_index);
        pix        <= item.intensity;
        slot_start <= item.slot_start;
      end
      ST_CHECK: begin
        prod <= 40'(diff[15:0]) * 40'(rate_gain);
      end
      ST_RATE: begin
        rate  <= rate_sum;
        u     <= mem_q.started ? mem_q.unwarped : first_spike_delay;
        fired <= mem_q.started & mem_q.fired;
        last  <= {3'd0, mem_q.last_spike};
        count <= '0;
        trunc <= 1'b0;
        rem   <= '0;
        dvd   <= {(mem_q.started ? mem_q.unwarped : first_spike_delay), 4'd0};
        step  <= '0;
      end
      ST_DIV: begin
        rem  <= div_ge ? 33'(div_sh - {1'b0, rate}) : div_sh[32:0];
        dvd  <= {dvd[34:0], div_ge};
        step <= step + 6'd1;
      end
      ST_CAND: begin
        if (rel < {11'd0, slot_length}) begin
          if (count == CW'(MAX_SPIKES)) begin
            trunc <= 1'b1;
          end else begin
            count <= count + CW'(1);
            last  <= t_c;
            fired <= 1'b1;
            u     <= u_inc[32] ? 32'hFFFF_FFFF : u_inc[31:0];
            rem   <= '0;
            dvd   <= {(u_inc[32] ? 32'hFFFF_FFFF : u_inc[31:0]), 4'd0};
            step  <= '0;
          end
        end
      end
      ST_DEC_MUL: begin
        p_hi <= 49'(slot_length) * 49'(rate[32:16]);
        p_lo <= 48'(slot_length) * 48'(rate[15:0]);
      end
      ST_DEC_SUB: begin
        rd_idx <= '0;
      end
      ST_SHOW: begin
        rd_idx <= rd_idx + CW'(1);
      end
      default: ;
    endcase
  end

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_SHOW);
  assign result = '{spike_neuron: idx, spike_time: buf_q,
                    last_of_run: (rd_idx == count - CW'(1)), truncated: trunc};

endmodule
